// File: sv/eshd_pkg.sv
package eshd_pkg;

  // Micro-operations carried out by the datapath in one step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RECIP,
    OP_REM,
    OP_DAYS,
    OP_WDAY,
    OP_YEAR,
    OP_MONTH,
    OP_MDAY,
    OP_HOUR,
    OP_EMIT
  } op_t;

  // Constant divisors of the reciprocal divide steps.
  typedef enum logic [2:0] {
    DV_DAY,
    DV_WEEK,
    DV_QUAD,
    DV_HOUR,
    DV_MIN
  } dsel_t;

  // How the step counter moves after a step.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_LOOP_MONTH,
    JC_WAIT_IN,
    JC_WAIT_FMT
  } jcond_t;

  localparam int unsigned PC_W = 5;

  typedef struct packed {
    op_t                op;
    dsel_t              dsel;
    jcond_t             jc;
    logic [PC_W-1:0]    target;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t              op;
    dsel_t            dsel;
  } dp_ctrl_t;

  // Calendar fields handed from the datapath to the formatter.
  typedef struct packed {
    logic [2:0] wday;
    logic [4:0] mday;
    logic [3:0] month;
    logic [7:0] year_off;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } fields_t;

  localparam logic [31:0] LAST_SECOND = 32'd4102444799;
  localparam int unsigned LINE_LEN    = 31;

endpackage

// File: sv/epoch_seconds_to_http_date_unit.sv
// Converts a Unix timestamp in seconds into the HTTP date line
// "Www, DD Mon YYYY HH:MM:SS GMT" followed by CR LF, sent as 31 beats of one
// ASCII character each; the line feed beat carries out_last_byte.
// Both channels use valid/ready; a beat moves when valid and ready are high
// at a rising clock edge. Timestamps past the end of 2099 read as the last
// second of 2099.
// A small microcoded sequencer drives a datapath that divides by constants
// with a reciprocal multiply and a multiply-back step each: seconds by 86400,
// days by 7, days by 1461, then a month walk and the hour and minute splits.
// From acceptance to hand-off the sequencer runs sixteen steps plus the month
// walk, which stays on its step once for each month visited. The output goes
// valid at the hand-off edge. The formatter holds the fields while it sends,
// so the sequencer takes and works on the next timestamp while the line goes
// out; the formatter takes a new set of fields once its last beat has moved.
// When the receiver stalls, the current character simply holds; the
// sequencer waits at hand-off until the formatter has sent its last beat.
// Synchronous reset clears the step counter and the output state; the block
// is ready for a timestamp as soon as reset is released.
module epoch_seconds_to_http_date_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_text_byte,
  output logic        out_last_byte
);

  eshd_pkg::dp_ctrl_t ctrl;
  eshd_pkg::fields_t  fields;
  logic               month_done;
  logic               fmt_ready;
  logic               fmt_load;

  // Step counter and program table.
  eshd_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .month_done (month_done),
    .fmt_ready  (fmt_ready),
    .in_ready   (in_ready),
    .fmt_load   (fmt_load),
    .ctrl       (ctrl)
  );

  // Accumulator, quotient and the calendar field registers.
  eshd_datapath u_dp (
    .clk              (clk),
    .ctrl             (ctrl),
    .in_epoch_seconds (in_epoch_seconds),
    .month_done       (month_done),
    .fields           (fields)
  );

  // Holds one set of fields and streams the line out, one character a beat.
  eshd_formatter u_fmt (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (fmt_load),
    .fields        (fields),
    .ready         (fmt_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_byte (out_text_byte),
    .out_last_byte (out_last_byte)
  );

  // After taking a timestamp the sequencer moves on to the divide steps.
  a_in_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready right after a timestamp was taken");

  // The formatter is loaded only while it has nothing left to send.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fmt_load |-> !out_valid)
    else $error("formatter loaded while a line was still going out");

  // Once the line feed beat is taken the output goes idle.
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_byte) |=> !out_valid)
    else $error("output still valid after the last beat of a line");

  // A line always starts at its first character.
  a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    fmt_load |=> (out_valid && !out_last_byte))
    else $error("line did not start at its first character");

endmodule

// File: sv/eshd_sequencer.sv
module eshd_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                month_done,
  input  logic                fmt_ready,
  output logic                in_ready,
  output logic                fmt_load,
  output eshd_pkg::dp_ctrl_t  ctrl
);

  logic [eshd_pkg::PC_W-1:0]  pc_r, pc_nxt;
  eshd_pkg::uword_t           uw;

  function automatic eshd_pkg::uword_t mk(input eshd_pkg::op_t op,
                                          input eshd_pkg::dsel_t ds,
                                          input eshd_pkg::jcond_t jc);
    eshd_pkg::uword_t w;
    w = '{op: op, dsel: ds, jc: jc, target: '0};
    return w;
  endfunction

  // The program. Every divide by a constant is a reciprocal multiply that
  // gives the quotient, followed by a multiply-back step that leaves the
  // remainder in the accumulator.
  function automatic eshd_pkg::uword_t rom(input logic [eshd_pkg::PC_W-1:0] a);
    eshd_pkg::uword_t w;
    unique case (a)
      5'd0:    w = mk(eshd_pkg::OP_LOAD,  eshd_pkg::DV_DAY,  eshd_pkg::JC_WAIT_IN);
      5'd1:    w = mk(eshd_pkg::OP_RECIP, eshd_pkg::DV_DAY,  eshd_pkg::JC_NEXT);
      5'd2:    w = mk(eshd_pkg::OP_REM,   eshd_pkg::DV_DAY,  eshd_pkg::JC_NEXT);
      5'd3:    w = mk(eshd_pkg::OP_DAYS,  eshd_pkg::DV_DAY,  eshd_pkg::JC_NEXT);
      5'd4:    w = mk(eshd_pkg::OP_RECIP, eshd_pkg::DV_WEEK, eshd_pkg::JC_NEXT);
      5'd5:    w = mk(eshd_pkg::OP_REM,   eshd_pkg::DV_WEEK, eshd_pkg::JC_NEXT);
      5'd6:    w = mk(eshd_pkg::OP_WDAY,  eshd_pkg::DV_WEEK, eshd_pkg::JC_NEXT);
      5'd7:    w = mk(eshd_pkg::OP_RECIP, eshd_pkg::DV_QUAD, eshd_pkg::JC_NEXT);
      5'd8:    w = mk(eshd_pkg::OP_REM,   eshd_pkg::DV_QUAD, eshd_pkg::JC_NEXT);
      5'd9:    w = mk(eshd_pkg::OP_YEAR,  eshd_pkg::DV_QUAD, eshd_pkg::JC_NEXT);
      5'd10:   w = mk(eshd_pkg::OP_MONTH, eshd_pkg::DV_QUAD, eshd_pkg::JC_LOOP_MONTH);
      5'd11:   w = mk(eshd_pkg::OP_MDAY,  eshd_pkg::DV_QUAD, eshd_pkg::JC_NEXT);
      5'd12:   w = mk(eshd_pkg::OP_RECIP, eshd_pkg::DV_HOUR, eshd_pkg::JC_NEXT);
      5'd13:   w = mk(eshd_pkg::OP_REM,   eshd_pkg::DV_HOUR, eshd_pkg::JC_NEXT);
      5'd14:   w = mk(eshd_pkg::OP_HOUR,  eshd_pkg::DV_HOUR, eshd_pkg::JC_NEXT);
      5'd15:   w = mk(eshd_pkg::OP_RECIP, eshd_pkg::DV_MIN,  eshd_pkg::JC_NEXT);
      5'd16:   w = mk(eshd_pkg::OP_REM,   eshd_pkg::DV_MIN,  eshd_pkg::JC_NEXT);
      5'd17:   w = mk(eshd_pkg::OP_EMIT,  eshd_pkg::DV_MIN,  eshd_pkg::JC_WAIT_FMT);
      default: w = mk(eshd_pkg::OP_NOP,   eshd_pkg::DV_DAY,  eshd_pkg::JC_GOTO);
    endcase
    return w;
  endfunction

  assign uw       = rom(pc_r);
  assign in_ready = (uw.op == eshd_pkg::OP_LOAD);
  assign fmt_load = (uw.op == eshd_pkg::OP_EMIT) && fmt_ready;
  assign ctrl     = '{op: uw.op, dsel: uw.dsel};

  always_comb begin
    pc_nxt = pc_r + 5'd1;
    unique case (uw.jc)
      eshd_pkg::JC_NEXT:       pc_nxt = pc_r + 5'd1;
      eshd_pkg::JC_GOTO:       pc_nxt = uw.target;
      eshd_pkg::JC_LOOP_MONTH: pc_nxt = month_done ? pc_r + 5'd1 : pc_r;
      eshd_pkg::JC_WAIT_IN:    pc_nxt = in_valid ? pc_r + 5'd1 : pc_r;
      eshd_pkg::JC_WAIT_FMT:   pc_nxt = fmt_ready ? uw.target : pc_r;
      default:                 pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: sv/eshd_datapath.sv
module eshd_datapath (
  input  logic                clk,
  input  eshd_pkg::dp_ctrl_t  ctrl,
  input  logic [31:0]         in_epoch_seconds,
  output logic                month_done,
  output eshd_pkg::fields_t   fields
);

  logic [31:0] acc_r, acc_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] days_r, days_nxt;
  logic [16:0] sod_r, sod_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [7:0]  year_off_r, year_off_nxt;
  logic        leap_r, leap_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  mday_r, mday_nxt;
  logic [4:0]  hour_r, hour_nxt;

  logic [24:0] rcp_x;
  logic [25:0] rcp_m;
  logic [5:0]  rcp_k;
  logic [50:0] rcp_prod;
  logic [15:0] rcp_q;
  logic [32:0] back_prod;
  logic [4:0]  mlen;
  logic [3:0]  wsum;
  logic [10:0] qrem;
  logic [1:0]  yq;
  logic [10:0] ycum;

  function automatic logic [16:0] divisor(input eshd_pkg::dsel_t d);
    logic [16:0] v;
    unique case (d)
      eshd_pkg::DV_DAY:  v = 17'd86400;
      eshd_pkg::DV_WEEK: v = 17'd7;
      eshd_pkg::DV_QUAD: v = 17'd1461;
      eshd_pkg::DV_HOUR: v = 17'd3600;
      eshd_pkg::DV_MIN:  v = 17'd60;
      default:           v = 17'd1;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] mon_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    unique case (m)
      4'd1:                         v = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:      v = 5'd30;
      default:                      v = 5'd31;
    endcase
    return v;
  endfunction

  // The dividend drops the divisor's power-of-two factor first; then
  // (x * m) >> k is the exact quotient over every value x can take here.
  always_comb begin
    unique case (ctrl.dsel)
      eshd_pkg::DV_DAY: begin
        rcp_x = acc_r[31:7];
        rcp_m = 26'd50903317;
        rcp_k = 6'd35;
      end
      eshd_pkg::DV_WEEK: begin
        rcp_x = {9'd0, acc_r[15:0]};
        rcp_m = 26'd74899;
        rcp_k = 6'd19;
      end
      eshd_pkg::DV_QUAD: begin
        rcp_x = {9'd0, acc_r[15:0]};
        rcp_m = 26'd91868;
        rcp_k = 6'd27;
      end
      eshd_pkg::DV_HOUR: begin
        rcp_x = {12'd0, acc_r[16:4]};
        rcp_m = 26'd9321;
        rcp_k = 6'd21;
      end
      eshd_pkg::DV_MIN: begin
        rcp_x = {15'd0, acc_r[11:2]};
        rcp_m = 26'd1093;
        rcp_k = 6'd14;
      end
      default: begin
        rcp_x = acc_r[24:0];
        rcp_m = 26'd1;
        rcp_k = 6'd0;
      end
    endcase
  end

  assign rcp_prod   = {26'd0, rcp_x} * {25'd0, rcp_m};
  assign rcp_q      = 16'(rcp_prod >> rcp_k);
  assign back_prod  = {17'd0, quo_r} * {16'd0, divisor(ctrl.dsel)};
  assign mlen       = mon_len(month_r, leap_r);
  assign month_done = (acc_r < {27'd0, mlen}) || (month_r == 4'd11);
  assign wsum       = {1'b0, acc_r[2:0]} + 4'd4;
  assign qrem       = acc_r[10:0];

  // Place within the four-year cycle that starts in 1970; its third year is leap.
  always_comb begin
    priority if (qrem < 11'd365) begin
      yq = 2'd0; ycum = 11'd0;
    end else if (qrem < 11'd730) begin
      yq = 2'd1; ycum = 11'd365;
    end else if (qrem < 11'd1096) begin
      yq = 2'd2; ycum = 11'd730;
    end else begin
      yq = 2'd3; ycum = 11'd1096;
    end
  end

  always_comb begin
    acc_nxt      = acc_r;
    quo_nxt      = quo_r;
    days_nxt     = days_r;
    sod_nxt      = sod_r;
    wday_nxt     = wday_r;
    year_off_nxt = year_off_r;
    leap_nxt     = leap_r;
    month_nxt    = month_r;
    mday_nxt     = mday_r;
    hour_nxt     = hour_r;
    unique case (ctrl.op)
      eshd_pkg::OP_LOAD: begin
        acc_nxt = (in_epoch_seconds > eshd_pkg::LAST_SECOND) ?
                  eshd_pkg::LAST_SECOND : in_epoch_seconds;
      end
      eshd_pkg::OP_RECIP: quo_nxt = rcp_q;
      eshd_pkg::OP_REM:   acc_nxt = acc_r - back_prod[31:0];
      eshd_pkg::OP_DAYS: begin
        sod_nxt  = acc_r[16:0];
        days_nxt = quo_r;
        acc_nxt  = {16'd0, quo_r};
      end
      eshd_pkg::OP_WDAY: begin
        wday_nxt = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
        acc_nxt  = {16'd0, days_r};
      end
      eshd_pkg::OP_YEAR: begin
        year_off_nxt = {quo_r[5:0], yq};
        leap_nxt     = (yq == 2'd2);
        month_nxt    = '0;
        acc_nxt      = {21'd0, qrem - ycum};
      end
      eshd_pkg::OP_MONTH: begin
        if (!month_done) begin
          acc_nxt   = acc_r - {27'd0, mlen};
          month_nxt = month_r + 4'd1;
        end
      end
      eshd_pkg::OP_MDAY: begin
        mday_nxt = acc_r[4:0] + 5'd1;
        acc_nxt  = {15'd0, sod_r};
      end
      eshd_pkg::OP_HOUR: hour_nxt = quo_r[4:0];
      eshd_pkg::OP_NOP, eshd_pkg::OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    quo_r      <= quo_nxt;
    days_r     <= days_nxt;
    sod_r      <= sod_nxt;
    wday_r     <= wday_nxt;
    year_off_r <= year_off_nxt;
    leap_r     <= leap_nxt;
    month_r    <= month_nxt;
    mday_r     <= mday_nxt;
    hour_r     <= hour_nxt;
  end

  // Minutes and seconds are still in the quotient and remainder at hand-off.
  assign fields = '{wday: wday_r, mday: mday_r, month: month_r, year_off: year_off_r,
                    hour: hour_r, minute: quo_r[5:0], second: acc_r[5:0]};

endmodule

// File: sv/eshd_formatter.sv
module eshd_formatter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  eshd_pkg::fields_t  fields,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_text_byte,
  output logic               out_last_byte
);

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_COMMA = 7'h2C;
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_G     = 7'h47;
  localparam logic [6:0] CH_M     = 7'h4D;
  localparam logic [6:0] CH_T     = 7'h54;
  localparam logic [4:0] LAST_POS = 5'(eshd_pkg::LINE_LEN - 1);

  logic              busy_r, busy_nxt;
  logic [4:0]        pos_r, pos_nxt;
  eshd_pkg::fields_t fld_r, fld_nxt;

  logic [2:0][6:0]   wname, mname;
  logic [6:0]        yy;
  logic [7:0]        d_mday, d_year, d_hour, d_min, d_sec;
  logic              modern;

  function automatic logic [2:0][6:0] pack3(input logic [23:0] s);
    return {s[22:16], s[14:8], s[6:0]};
  endfunction

  function automatic logic [2:0][6:0] wday_name(input logic [2:0] w);
    logic [2:0][6:0] n;
    unique case (w)
      3'd1:    n = pack3("Mon");
      3'd2:    n = pack3("Tue");
      3'd3:    n = pack3("Wed");
      3'd4:    n = pack3("Thu");
      3'd5:    n = pack3("Fri");
      3'd6:    n = pack3("Sat");
      default: n = pack3("Sun");
    endcase
    return n;
  endfunction

  function automatic logic [2:0][6:0] mon_name(input logic [3:0] m);
    logic [2:0][6:0] n;
    unique case (m)
      4'd1:    n = pack3("Feb");
      4'd2:    n = pack3("Mar");
      4'd3:    n = pack3("Apr");
      4'd4:    n = pack3("May");
      4'd5:    n = pack3("Jun");
      4'd6:    n = pack3("Jul");
      4'd7:    n = pack3("Aug");
      4'd8:    n = pack3("Sep");
      4'd9:    n = pack3("Oct");
      4'd10:   n = pack3("Nov");
      4'd11:   n = pack3("Dec");
      default: n = pack3("Jan");
    endcase
    return n;
  endfunction

  // Tens and ones of a value below 100; v*205 >> 11 equals v/10 there.
  function automatic logic [7:0] two_digit(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    ones = v - ({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [6:0] dig(input logic [3:0] d);
    return CH_ZERO + {3'd0, d};
  endfunction

  assign wname  = wday_name(fld_r.wday);
  assign mname  = mon_name(fld_r.month);
  assign modern = (fld_r.year_off >= 8'd30);
  assign yy     = modern ? 7'(fld_r.year_off - 8'd30) : 7'(fld_r.year_off + 8'd70);
  assign d_mday = two_digit({2'd0, fld_r.mday});
  assign d_year = two_digit(yy);
  assign d_hour = two_digit({2'd0, fld_r.hour});
  assign d_min  = two_digit({1'd0, fld_r.minute});
  assign d_sec  = two_digit({1'd0, fld_r.second});

  always_comb begin
    unique case (pos_r)
      5'd0:    out_text_byte = wname[2];
      5'd1:    out_text_byte = wname[1];
      5'd2:    out_text_byte = wname[0];
      5'd3:    out_text_byte = CH_COMMA;
      5'd5:    out_text_byte = dig(d_mday[7:4]);
      5'd6:    out_text_byte = dig(d_mday[3:0]);
      5'd8:    out_text_byte = mname[2];
      5'd9:    out_text_byte = mname[1];
      5'd10:   out_text_byte = mname[0];
      5'd12:   out_text_byte = modern ? dig(4'd2) : dig(4'd1);
      5'd13:   out_text_byte = modern ? dig(4'd0) : dig(4'd9);
      5'd14:   out_text_byte = dig(d_year[7:4]);
      5'd15:   out_text_byte = dig(d_year[3:0]);
      5'd17:   out_text_byte = dig(d_hour[7:4]);
      5'd18:   out_text_byte = dig(d_hour[3:0]);
      5'd19:   out_text_byte = CH_COLON;
      5'd20:   out_text_byte = dig(d_min[7:4]);
      5'd21:   out_text_byte = dig(d_min[3:0]);
      5'd22:   out_text_byte = CH_COLON;
      5'd23:   out_text_byte = dig(d_sec[7:4]);
      5'd24:   out_text_byte = dig(d_sec[3:0]);
      5'd26:   out_text_byte = CH_G;
      5'd27:   out_text_byte = CH_M;
      5'd28:   out_text_byte = CH_T;
      5'd29:   out_text_byte = CH_CR;
      5'd30:   out_text_byte = CH_LF;
      default: out_text_byte = CH_SPACE;
    endcase
  end

  assign ready         = !busy_r;
  assign out_valid     = busy_r;
  assign out_last_byte = (pos_r == LAST_POS);

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    fld_nxt  = fld_r;
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
      fld_nxt  = fields;
    end else if (busy_r && out_ready) begin
      if (out_last_byte) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fld_r <= fld_nxt;
  end

endmodule
